@@ rtl/core/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter package
// Shared types, limits and the month length lookup of the calendar counter.
// ----------------------------------------------------------------------------
package ctc_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  localparam int TICK_MS_DEFAULT = 10;

  localparam int MILLIS_W  = 10;
  localparam int SECONDS_W = 6;
  localparam int MINUTES_W = 6;
  localparam int HOURS_W   = 5;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 7;
  localparam int WEEKDAY_W = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [MILLIS_W:0]    MS_PER_SEC  = 11'd1000;
  localparam logic [SECONDS_W-1:0] SEC_LAST    = 6'd59;
  localparam logic [MINUTES_W-1:0] MIN_LAST    = 6'd59;
  localparam logic [HOURS_W-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MONTH_W-1:0]   MONTH_LAST  = 4'd12;
  localparam logic [YEAR_W-1:0]    YEAR_LAST   = 7'd99;
  localparam logic [WEEKDAY_W-1:0] WDAY_LAST   = 3'd6;
  localparam logic [DAY_W-1:0]     DAY_FIRST   = 5'd1;
  localparam logic [MONTH_W-1:0]   MONTH_FIRST = 4'd1;
  localparam logic [WEEKDAY_W-1:0] WDAY_RESET  = 3'd6;

  function automatic logic [DAY_W-1:0] month_length(
    input logic [MONTH_W-1:0] month,
    input logic [YEAR_W-1:0]  year
  );
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:                      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/calendar_time_counter_core.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter core
// Millisecond, time of day and date counter with tick and load words.
// ----------------------------------------------------------------------------
//  Channel | Direction | tuser          | tdata
//  in_     | slave     | operation      | load_seconds .. load_weekday
//  out_    | master    | (none)         | now_millis .. now_weekday
//
// Every accepted word is handled at once; one result word follows on the next
// cycle and a new word can be taken on every clock while the output is not stalled.
// The counters update in a single pass from the held state, so the cascade
// of compares from milliseconds to year sets the cycle time.
// While the result word is stalled, in_tready is low unless it is taken.
// Reset sets 2000-01-01 00:00:00.000, Saturday, and empties the output.
module calendar_time_counter_core #(
  parameter int TICK_MS = ctc_pkg::TICK_MS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // bit 0: operation
  input  logic                            in_tuser,
  // load_seconds, load_minutes, load_hours, load_day, load_month,
  // load_year, load_weekday
  input  logic [ctc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // now_millis, now_seconds, now_minutes, now_hours, now_day, now_month,
  // now_year, now_weekday, zero fill
  output logic [ctc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ctc_pkg::*;

  logic                 out_valid_r;
  logic [MILLIS_W-1:0]  millis_r,  millis_nxt;
  logic [SECONDS_W-1:0] sec_r,     sec_nxt;
  logic [MINUTES_W-1:0] min_r,     min_nxt;
  logic [HOURS_W-1:0]   hour_r,    hour_nxt;
  logic [DAY_W-1:0]     day_r,     day_nxt;
  logic [MONTH_W-1:0]   month_r,   month_nxt;
  logic [YEAR_W-1:0]    year_r,    year_nxt;
  logic [WEEKDAY_W-1:0] wday_r,    wday_nxt;

  logic                 accept;
  op_t                  op;
  logic [MILLIS_W:0]    ms_sum;
  logic                 ms_wrap, sec_wrap, min_wrap, day_carry, month_wrap;
  logic [DAY_W-1:0]     mlen;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign op         = op_t'(in_tuser);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, wday_r, year_r, month_r, day_r, hour_r, min_r, sec_r,
                       millis_r};

  assign ms_sum     = {1'b0, millis_r} + (MILLIS_W+1)'(TICK_MS);
  assign ms_wrap    = ms_sum >= MS_PER_SEC;
  assign sec_wrap   = ms_wrap && (sec_r >= SEC_LAST);
  assign min_wrap   = sec_wrap && (min_r >= MIN_LAST);
  assign day_carry  = min_wrap && (hour_r >= HOUR_LAST);
  assign mlen       = month_length(month_r, year_r);
  assign month_wrap = day_carry && (day_r >= mlen) && (month_r >= MONTH_LAST);

  always_comb begin
    millis_nxt = millis_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    wday_nxt   = wday_r;
    if (op == OP_LOAD) begin
      millis_nxt = '0;
      sec_nxt    = in_tdata[5:0];
      min_nxt    = in_tdata[11:6];
      hour_nxt   = in_tdata[16:12];
      day_nxt    = in_tdata[21:17];
      month_nxt  = in_tdata[25:22];
      year_nxt   = in_tdata[32:26];
      wday_nxt   = in_tdata[35:33];
    end else begin
      millis_nxt = ms_wrap ? MILLIS_W'(ms_sum - MS_PER_SEC) : MILLIS_W'(ms_sum);
      if (ms_wrap) begin
        sec_nxt = (sec_r >= SEC_LAST) ? '0 : sec_r + 1'b1;
      end
      if (sec_wrap) begin
        min_nxt = (min_r >= MIN_LAST) ? '0 : min_r + 1'b1;
      end
      if (min_wrap) begin
        hour_nxt = (hour_r >= HOUR_LAST) ? '0 : hour_r + 1'b1;
      end
      if (day_carry) begin
        wday_nxt = (wday_r >= WDAY_LAST) ? '0 : wday_r + 1'b1;
        if (day_r >= mlen) begin
          day_nxt   = DAY_FIRST;
          month_nxt = (month_r >= MONTH_LAST) ? MONTH_FIRST : month_r + 1'b1;
        end else begin
          day_nxt = day_r + 1'b1;
        end
      end
      if (month_wrap) begin
        year_nxt = (year_r >= YEAR_LAST) ? '0 : year_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      millis_r    <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      day_r       <= DAY_FIRST;
      month_r     <= MONTH_FIRST;
      year_r      <= '0;
      wday_r      <= WDAY_RESET;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        millis_r    <= millis_nxt;
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        hour_r      <= hour_nxt;
        day_r       <= day_nxt;
        month_r     <= month_nxt;
        year_r      <= year_nxt;
        wday_r      <= wday_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  a_load_clears_millis: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_LOAD) |=> (millis_r == '0))
    else $error("load did not clear milliseconds");

  a_millis_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, millis_r} < MS_PER_SEC)
    else $error("milliseconds out of range");

  a_no_wrap_holds_seconds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_TICK && !ms_wrap) |=> $stable(sec_r))
    else $error("seconds changed without a millisecond wrap");

endmodule
